// ===== hdl/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types for the double-ended queue: item payloads, operation and
// status codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package deq_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic [4:0]         entry_count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_FRONT,
    S_RD_BACK,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_item;   // capture the accepted item
    logic exec;        // apply the operation to pointers and store
    logic op_ok;       // operation may proceed (not full / not empty)
    logic rd_front;    // read the front slot; latch removed value
    logic rd_back;     // read the back slot; latch front value
    logic load_out;    // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_pop;
    logic q_empty;
    logic q_full;
  } dp_status_t;

endpackage

// ===== hdl/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for one queue operation: accept, execute, read front, read back,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  deq_pkg::dp_status_t st_i,
  output deq_pkg::ctrl_cmd_t  cmd_o
);
  import deq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    // drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec  = 1'b1;
        cmd_o.op_ok = st_i.is_pop ? !st_i.q_empty : !st_i.q_full;
        state_d     = S_RD_FRONT;
      end
      S_RD_FRONT: begin
        cmd_o.rd_front = 1'b1;
        state_d        = S_RD_BACK;
      end
      S_RD_BACK: begin
        cmd_o.rd_back = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/deq_datapath.sv =====
// ----------------------------------------------------------------------------
// deq_datapath
// Ring buffer store with front pointer and entry count, one write port and
// one registered read port, plus the result register.
// ----------------------------------------------------------------------------
module deq_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  deq_pkg::in_item_t   in_item_i,
  input  deq_pkg::ctrl_cmd_t  cmd_i,
  output deq_pkg::dp_status_t st_o,
  output deq_pkg::out_item_t  out_item_o
);
  import deq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
  localparam logic [AW-1:0] LAST_I = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);

  logic signed [31:0] mem_q [CAPACITY];

  in_item_t           item_q;
  logic [AW-1:0]      front_q, front_d;
  logic [CW-1:0]      count_q, count_d;
  status_e            status_q;
  logic               pop_ok_q;
  logic signed [31:0] removed_q;
  logic signed [31:0] front_val_q;
  logic signed [31:0] rd_q;
  out_item_t          out_q;

  logic               is_push_front, is_pop_front, is_pop;
  logic [AW-1:0]      front_dec, front_inc, tail_idx, back_idx;
  logic [SW-1:0]      sum_tail, sum_back;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;

  assign is_pop        = (item_q.kind == KIND_POP_FRONT) || (item_q.kind == KIND_POP_BACK);
  assign is_push_front = (item_q.kind == KIND_PUSH_FRONT);
  assign is_pop_front  = (item_q.kind == KIND_POP_FRONT);

  assign front_dec = (front_q == '0) ? LAST_I : front_q - 1'b1;
  assign front_inc = (front_q == LAST_I) ? '0 : front_q + 1'b1;

  // slot just past the back, and the back slot itself
  assign sum_tail = SW'(front_q) + SW'(count_q);
  assign tail_idx = (sum_tail >= CAP_S) ? AW'(sum_tail - CAP_S) : AW'(sum_tail);
  assign sum_back = sum_tail - 1'b1;
  always_comb begin
    if (count_q == '0) begin
      back_idx = front_q;
    end else if (sum_back >= CAP_S) begin
      back_idx = AW'(sum_back - CAP_S);
    end else begin
      back_idx = AW'(sum_back);
    end
  end

  assign st_o.is_pop  = is_pop;
  assign st_o.q_empty = (count_q == '0);
  assign st_o.q_full  = (count_q >= CAP_C);

  // pointer and count update
  always_comb begin
    front_d = front_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = tail_idx;
    if (cmd_i.exec && cmd_i.op_ok) begin
      if (!is_pop) begin
        wr_en   = 1'b1;
        count_d = count_q + 1'b1;
        if (is_push_front) begin
          front_d = front_dec;
          wr_addr = front_dec;
        end
      end else begin
        count_d = count_q - 1'b1;
        if (is_pop_front) begin
          front_d = front_inc;
        end
      end
    end
  end

  // read port: popped slot, then new front, then new back
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = front_q;
    if (cmd_i.exec) begin
      rd_en   = cmd_i.op_ok && is_pop;
      rd_addr = is_pop_front ? front_q : back_idx;
    end else if (cmd_i.rd_front) begin
      rd_en   = 1'b1;
      rd_addr = front_q;
    end else if (cmd_i.rd_back) begin
      rd_en   = 1'b1;
      rd_addr = back_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= item_q.value;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.exec) begin
      pop_ok_q  <= cmd_i.op_ok && is_pop;
      removed_q <= '0;
      if (cmd_i.op_ok) begin
        status_q <= ST_DONE;
      end else if (is_pop) begin
        status_q <= ST_EMPTY;
      end else begin
        status_q <= ST_FULL;
      end
    end
    if (cmd_i.rd_front && pop_ok_q) begin
      removed_q <= rd_q;
    end
    if (cmd_i.rd_back) begin
      front_val_q <= rd_q;
    end
    if (cmd_i.load_out) begin
      out_q.status        <= status_q;
      out_q.removed_value <= removed_q;
      out_q.entry_count   <= 5'(count_q);
      out_q.front_value   <= (count_q == '0) ? '0 : front_val_q;
      out_q.back_value    <= (count_q == '0) ? '0 : rd_q;
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== hdl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit values in a ring buffer, with push and
// pop at either end and one status result per item.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------
//   input    | in_valid_i / in_ready_o | in_item_i  (kind, value)
//   output   | out_valid_o/out_ready_i | out_item_o (status, removed, count,
//            |                        |             front, back)
//
// One item at a time, in steps: accept, execute, then two reads of the single
// store read port (new front, new back) and the result load.
// The result register frees the input side: the next item is accepted while
// a result waits; the sequencer stalls in its last step only if the previous
// result is still untaken. Reset clears pointer and count; no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  deq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output deq_pkg::out_item_t out_item_o
);
  import deq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  deq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_item_o (out_item_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is in flight");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("loaded result not presented");

  a_no_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st.q_empty && st.q_full))
    else $error("queue reported empty and full at once");

endmodule
